FILE: rtl/two_axis_step_position_follower_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the two-axis step follower
// Shorthand for clocked implication checks, reset disables them.
// ---------------------------------------------------------------------------
`ifndef TWO_AXIS_STEP_POSITION_FOLLOWER_TOP_DEFINES_SVH
`define TWO_AXIS_STEP_POSITION_FOLLOWER_TOP_DEFINES_SVH

// same-cycle implication
`define TSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tsf_pkg.sv
// ---------------------------------------------------------------------------
// tsf_pkg
// Types and constants shared by the two-axis step follower.
// ---------------------------------------------------------------------------
package tsf_pkg;

  localparam int POS_BITS    = 24;
  localparam int SAMPLE_BITS = 8;
  localparam int HOST_BITS   = 16;
  localparam int SPC_BITS    = 8;
  localparam int BAND_BITS   = 16;
  localparam int PERSIST_BITS = 10;
  localparam int CNT_BITS    = 11;
  localparam int PROD_BITS   = HOST_BITS + SPC_BITS;
  localparam int WIDE_BITS   = POS_BITS + 2;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};

  localparam logic [SPC_BITS-1:0]     SPC_RESET     = 8'd75;
  localparam logic [BAND_BITS-1:0]    BAND_RESET    = 16'd1000;
  localparam logic [PERSIST_BITS-1:0] PERSIST_RESET = 10'd100;

  localparam logic [2:0] CMD_SAMPLE = 3'd0;
  localparam logic [2:0] CMD_TICK   = 3'd1;
  localparam logic [2:0] CMD_HOST_X = 3'd2;
  localparam logic [2:0] CMD_HOST_Y = 3'd3;
  localparam logic [2:0] CMD_HOME   = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_STEPS_PER_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEADBAND_STEPS  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PERSIST_LIMIT   = 2'd2;

  typedef struct packed {
    logic [2:0]             cmd;
    logic [SAMPLE_BITS-1:0] sample_x;
    logic [SAMPLE_BITS-1:0] sample_y;
    logic [HOST_BITS-1:0]   host_value;
    logic                   limit_x;
    logic                   limit_y;
  } req_t;

  typedef struct packed {
    logic                       step_x;
    logic                       dir_x;
    logic                       step_y;
    logic                       dir_y;
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    logic signed [POS_BITS-1:0] target_x;
    logic signed [POS_BITS-1:0] target_y;
    logic                       homed;
  } res_t;

  typedef struct packed {
    logic sample;
    logic tick;
    logic host;
    logic home;
  } axis_op_t;

  typedef struct packed {
    logic                       step;
    logic                       dir;
    logic signed [POS_BITS-1:0] pos;
    logic signed [POS_BITS-1:0] target;
  } axis_res_t;

endpackage

FILE: rtl/two_axis_step_position_follower_top.sv
// ---------------------------------------------------------------------------
// two_axis_step_position_follower_top
// Two-axis stepper setpoint follower with sample persistence filtering.
// ---------------------------------------------------------------------------
// Each request runs through an input register and a result register with
// combinational logic between them, so one request per cycle is taken while
// the output is not stalled. The critical path is the 16x8 scaling multiply
// followed by the signed deadband compare and counter update of an axis.
// Both sides may stall freely; two requests can be held.
module two_axis_step_position_follower_top import tsf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  req_t                     req,
  output logic                     res_valid,
  input  logic                     res_stall,
  output res_t                     res,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

`include "two_axis_step_position_follower_top_defines.svh"

  logic [SPC_BITS-1:0]     steps_per_count;
  logic [BAND_BITS-1:0]    deadband_steps;
  logic [PERSIST_BITS-1:0] persist_limit;

  req_t  s1;
  logic  s1_valid;
  logic  advance, fire;
  res_t  res_next;

  logic signed [POS_BITS-1:0] sx_steps, sy_steps, host_steps;
  axis_op_t  op_x, op_y;
  axis_res_t ax_x, ax_y;

  assign advance   = !res_valid || !res_stall;
  assign fire      = s1_valid && advance;
  assign req_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_count <= SPC_RESET;
      deadband_steps  <= BAND_RESET;
      persist_limit   <= PERSIST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEPS_PER_COUNT: steps_per_count <= cfg_data[SPC_BITS-1:0];
        CFG_DEADBAND_STEPS:  deadband_steps  <= cfg_data[BAND_BITS-1:0];
        CFG_PERSIST_LIMIT:   persist_limit   <= cfg_data[PERSIST_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) s1 <= req;
  end

  tsf_scale u_scale_x (
    .value           (HOST_BITS'(s1.sample_x)),
    .steps_per_count (steps_per_count),
    .scaled          (sx_steps)
  );

  tsf_scale u_scale_y (
    .value           (HOST_BITS'(s1.sample_y)),
    .steps_per_count (steps_per_count),
    .scaled          (sy_steps)
  );

  tsf_scale u_scale_host (
    .value           (s1.host_value),
    .steps_per_count (steps_per_count),
    .scaled          (host_steps)
  );

  always_comb begin
    op_x.sample = (s1.cmd == CMD_SAMPLE);
    op_x.tick   = (s1.cmd == CMD_TICK);
    op_x.host   = (s1.cmd == CMD_HOST_X);
    op_x.home   = (s1.cmd == CMD_HOME);
    op_y        = op_x;
    op_y.host   = (s1.cmd == CMD_HOST_Y);
  end

  tsf_axis u_axis_x (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .op           (op_x),
    .sample_steps (sx_steps),
    .host_steps   (host_steps),
    .limit        (s1.limit_x),
    .deadband     (deadband_steps),
    .persist      (persist_limit),
    .res          (ax_x)
  );

  tsf_axis u_axis_y (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .op           (op_y),
    .sample_steps (sy_steps),
    .host_steps   (host_steps),
    .limit        (s1.limit_y),
    .deadband     (deadband_steps),
    .persist      (persist_limit),
    .res          (ax_y)
  );

  always_comb begin
    res_next.step_x   = ax_x.step;
    res_next.dir_x    = ax_x.dir;
    res_next.step_y   = ax_y.step;
    res_next.dir_y    = ax_y.dir;
    res_next.pos_x    = ax_x.pos;
    res_next.pos_y    = ax_y.pos;
    res_next.target_x = ax_x.target;
    res_next.target_y = ax_y.target;
    res_next.homed    = (s1.cmd == CMD_HOME) && s1.limit_x && s1.limit_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res <= res_next;
  end

  // input is held back only while both stages are occupied
  `TSF_ASSERT_IMP(a_stall_full, req_stall, s1_valid && res_valid && res_stall, "stall without full pipe")
  `TSF_ASSERT_IMP(a_homed_no_step, res_valid && res.homed, !res.step_x && !res.step_y, "homed with step")
  `TSF_ASSERT_IMP(a_fwd_x, res_valid && res.step_x && res.dir_x, res.pos_x <= res.target_x, "x overshoot")
  `TSF_ASSERT_NXT(a_hold_res, res_valid && res_stall, res_valid && $stable(res), "response lost")

endmodule

FILE: rtl/tsf_scale.sv
// ---------------------------------------------------------------------------
// tsf_scale
// Scales a count value to motor steps, saturating at the largest position.
// ---------------------------------------------------------------------------
module tsf_scale import tsf_pkg::*; (
  input  logic [HOST_BITS-1:0]       value,
  input  logic [SPC_BITS-1:0]        steps_per_count,
  output logic signed [POS_BITS-1:0] scaled
);

  logic [PROD_BITS-1:0] product;

  assign product = value * steps_per_count;
  assign scaled  = ({1'b0, product} > (PROD_BITS+1)'(POS_MAX)) ? POS_MAX
                                                                : POS_BITS'(product);

endmodule

FILE: rtl/tsf_axis.sv
// ---------------------------------------------------------------------------
// tsf_axis
// One axis: target, position and persistence counters with their updates.
// ---------------------------------------------------------------------------
module tsf_axis import tsf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  axis_op_t                   op,
  input  logic signed [POS_BITS-1:0] sample_steps,
  input  logic signed [POS_BITS-1:0] host_steps,
  input  logic                       limit,
  input  logic [BAND_BITS-1:0]       deadband,
  input  logic [PERSIST_BITS-1:0]    persist,
  output axis_res_t                  res
);

  logic signed [POS_BITS-1:0] target, target_next;
  logic signed [POS_BITS-1:0] pos, pos_next;
  logic [CNT_BITS-1:0]        above, above_next;
  logic [CNT_BITS-1:0]        below, below_next;
  logic signed [WIDE_BITS-1:0] t_w, s_w, b_w;
  logic [CNT_BITS-1:0]        above_up, below_up;
  logic                       step, dir;

  assign t_w = WIDE_BITS'(target);
  assign s_w = WIDE_BITS'(sample_steps);
  assign b_w = signed'({{(WIDE_BITS-BAND_BITS){1'b0}}, deadband});
  assign above_up = (above == CNT_MAX) ? above : above + 1'b1;
  assign below_up = (below == CNT_MAX) ? below : below + 1'b1;

  always_comb begin
    target_next = target;
    pos_next    = pos;
    above_next  = above;
    below_next  = below;
    step        = 1'b0;
    dir         = 1'b0;
    if (op.sample) begin
      if (t_w > s_w + b_w) begin
        below_next = '0;
        above_next = above_up;
        if (above_up > CNT_BITS'(persist)) target_next = sample_steps;
      end else if (t_w < s_w - b_w) begin
        above_next = '0;
        below_next = below_up;
        if (below_up > CNT_BITS'(persist)) target_next = sample_steps;
      end
    end else if (op.tick) begin
      if (target > pos) begin
        step     = 1'b1;
        dir      = 1'b1;
        pos_next = pos + POS_BITS'(1);
      end else if (target < pos) begin
        step     = 1'b1;
        pos_next = pos - POS_BITS'(1);
      end
    end else if (op.host) begin
      target_next = host_steps;
    end else if (op.home) begin
      step = !limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
      pos    <= '0;
      above  <= '0;
      below  <= '0;
    end else if (fire) begin
      target <= target_next;
      pos    <= pos_next;
      above  <= above_next;
      below  <= below_next;
    end
  end

  assign res.step   = step;
  assign res.dir    = dir;
  assign res.pos    = pos_next;
  assign res.target = target_next;

endmodule
